// File: src/mips_subset_instruction_execute_core_macros.svh
// assertion helpers
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTE_CORE_MACROS_SVH

// same-cycle implication
`define MSIEC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSIEC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/msiec_pkg.sv
`default_nettype none
package msiec_pkg;

	localparam int DATA_AW = 8;

	localparam logic [1:0] REQ_EXEC    = 2'd0;
	localparam logic [1:0] REQ_PRELOAD = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_NORI  = 6'h0E;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LB    = 6'h20;
	localparam logic [5:0] OP_LH    = 6'h21;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_LBU   = 6'h24;
	localparam logic [5:0] OP_LHU   = 6'h25;
	localparam logic [5:0] OP_SB    = 6'h28;
	localparam logic [5:0] OP_SH    = 6'h29;
	localparam logic [5:0] OP_SW    = 6'h2B;
	localparam logic [5:0] OP_HALT  = 6'h3F;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_NAND = 6'h28;
	localparam logic [5:0] FN_SLT  = 6'h2A;

	localparam logic [4:0] REG_SP = 5'd29;
	localparam logic [4:0] REG_RA = 5'd31;

	localparam logic CFG_START_PC = 1'b0;
	localparam logic CFG_INIT_SP  = 1'b1;

	// first field in the highest bits
	typedef struct packed {
		logic        halted;
		logic [31:0] mem_value;
		logic [31:0] mem_address;
		logic        mem_written;
		logic [31:0] dest_value;
		logic [4:0]  dest_reg;
		logic        reg_written;
		logic [31:0] pc_after;
	} result_t;

endpackage
`default_nettype wire

// File: src/msiec_ram.sv
`default_nettype none
module msiec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-edge write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: src/mips_subset_instruction_execute_core.sv
`default_nettype none
// Executes one MIPS-subset instruction word, data-memory preload or restart per word on the
// slave stream and returns one result word per item on the master stream, in order. A
// three-stage pipeline (register file read, effective address and data memory read, execute
// and write back into the result register) takes a new word every cycle, and only a stalled
// master side slows it. Register and memory values are forwarded, so dependent instructions
// run back to back. Data memory holds 2**DATA_AW words; a load from a word never preloaded or
// stored returns an undefined value.
`include "mips_subset_instruction_execute_core_macros.svh"
module mips_subset_instruction_execute_core #(
	parameter int DATA_AW = msiec_pkg::DATA_AW
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// instr_word[31:0], preload_index[39:32], preload_word[71:40]
	input  wire logic [71:0]  s_tdata,
	// req_type[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// pc_after[31:0], reg_written[32], dest_reg[37:33], dest_value[69:38],
	// mem_written[70], mem_address[102:71], mem_value[134:103], halted[135]
	output logic [135:0]      m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam int DATA_WORDS = 2 ** DATA_AW;

	logic [31:0] start_pc_q, init_sp_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == msiec_pkg::CFG_INIT_SP) ? init_sp_q : start_pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= '0;
			init_sp_q  <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == msiec_pkg::CFG_START_PC) start_pc_q <= pwdata;
			else init_sp_q <= pwdata;
		end
	end

	logic valid_s1, valid_s2, en1, en2, s_acc;
	logic [1:0]  req_s1, req_s2;
	logic [31:0] iw_s1, iw_s2, pw_s1, pw_s2, ea_s2, a_s2, b_s2;
	logic [7:0]  pidx_s1, pidx_s2;
	logic        ova_q, ovb_q, dov_q;
	logic [31:0] vala_q, valb_q, dval_q;
	logic [31:0] rf_rd_a, rf_rd_b, dm_rdata;
	logic [31:0] pc_q;
	logic        halt_q;
	logic [31:0] rf_valid_q;
	msiec_pkg::result_t out_q, res;

	logic        rf_we;
	logic [4:0]  rf_waddr;
	logic [31:0] rf_wdata;
	logic        dm_we;
	logic [DATA_AW-1:0] dm_waddr;
	logic [31:0] dm_wdata;
	logic [31:0] pc_nxt;
	logic        halt_nxt;

	assign en2      = valid_s2 && (!m_tvalid || m_tready);
	assign en1      = valid_s1 && (!valid_s2 || en2);
	assign s_tready = !valid_s1 || en1;
	assign s_acc    = s_tvalid && s_tready;

	wire [4:0] rs_in = s_tdata[25:21];
	wire [4:0] rt_in = s_tdata[20:16];
	wire [4:0] rs_s1 = iw_s1[25:21];
	wire [4:0] rt_s1 = iw_s1[20:16];
	wire       rf_wr_now = en2 && rf_we;

	msiec_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_wr_now), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(s_acc), .raddr(rs_in), .rdata(rf_rd_a)
	);
	msiec_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(rf_wr_now), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(s_acc), .raddr(rt_in), .rdata(rf_rd_b)
	);

	// stage 1 operands: late writes override the stored read
	logic [31:0] a1, b1, ea1;
	always_comb begin
		a1 = ova_q ? vala_q : rf_rd_a;
		b1 = ovb_q ? valb_q : rf_rd_b;
		if (valid_s2 && rf_we && rf_waddr == rs_s1) a1 = rf_wdata;
		if (valid_s2 && rf_we && rf_waddr == rt_s1) b1 = rf_wdata;
		ea1 = a1 + {{16{iw_s1[15]}}, iw_s1[15:0]};
	end

	wire [DATA_AW-1:0] widx1 = ea1[2 +: DATA_AW];

	msiec_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk(clk), .we(en2 && dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.re(en1), .raddr(widx1), .rdata(dm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_acc) valid_s1 <= 1'b1;
			else if (en1) valid_s1 <= 1'b0;
			if (en1) valid_s2 <= 1'b1;
			else if (en2) valid_s2 <= 1'b0;
			if (en2) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_s1  <= s_tuser;
			iw_s1   <= s_tdata[31:0];
			pidx_s1 <= s_tdata[39:32];
			pw_s1   <= s_tdata[71:40];
			ova_q   <= (rf_wr_now && rf_waddr == rs_in) || !rf_valid_q[rs_in];
			vala_q  <= (rf_wr_now && rf_waddr == rs_in) ? rf_wdata : '0;
			ovb_q   <= (rf_wr_now && rf_waddr == rt_in) || !rf_valid_q[rt_in];
			valb_q  <= (rf_wr_now && rf_waddr == rt_in) ? rf_wdata : '0;
		end else begin
			if (rf_wr_now && rf_waddr == rs_s1) begin
				ova_q  <= 1'b1;
				vala_q <= rf_wdata;
			end
			if (rf_wr_now && rf_waddr == rt_s1) begin
				ovb_q  <= 1'b1;
				valb_q <= rf_wdata;
			end
		end
		if (en1) begin
			req_s2  <= req_s1;
			iw_s2   <= iw_s1;
			pidx_s2 <= pidx_s1;
			pw_s2   <= pw_s1;
			a_s2    <= a1;
			b_s2    <= b1;
			ea_s2   <= ea1;
			dov_q   <= en2 && dm_we && dm_waddr == widx1;
			dval_q  <= dm_wdata;
		end
		if (en2) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			halt_q     <= 1'b0;
			rf_valid_q <= '0;
		end else if (en2) begin
			pc_q   <= pc_nxt;
			halt_q <= halt_nxt;
			if (rf_we) rf_valid_q[rf_waddr] <= 1'b1;
		end
	end

	// stage 2: execute
	logic [5:0]  op, fn;
	logic [4:0]  sh;
	logic [31:0] imm, zimm, nxt, word, v, pidx_w;
	logic [1:0]  off;
	logic        w, mw, known, ld;
	logic [4:0]  tgt;
	logic [7:0]  bsel;
	logic [15:0] hsel;

	always_comb begin
		op     = iw_s2[31:26];
		fn     = iw_s2[5:0];
		sh     = iw_s2[10:6];
		imm    = {{16{iw_s2[15]}}, iw_s2[15:0]};
		zimm   = {16'd0, iw_s2[15:0]};
		nxt    = pc_q + 32'd4;
		word   = dov_q ? dval_q : dm_rdata;
		off    = ea_s2[1:0];
		pidx_w = {24'd0, pidx_s2};
		w      = 1'b0;
		mw     = 1'b0;
		ld     = 1'b0;
		known  = 1'b1;
		tgt    = '0;
		v      = '0;
		pc_nxt   = pc_q;
		halt_nxt = halt_q;
		dm_we    = 1'b0;
		dm_waddr = ea_s2[2 +: DATA_AW];
		dm_wdata = '0;
		rf_we    = 1'b0;
		rf_waddr = '0;
		rf_wdata = '0;
		res      = '0;
		hsel = (off == 2'd0) ? word[31:16] : word[15:0];
		case (off)
			2'd0:    bsel = word[31:24];
			2'd1:    bsel = word[23:16];
			2'd2:    bsel = word[15:8];
			default: bsel = word[7:0];
		endcase

		if (req_s2 == msiec_pkg::REQ_PRELOAD) begin
			dm_we    = 1'b1;
			dm_waddr = pidx_w[DATA_AW-1:0];
			dm_wdata = pw_s2;
		end else if (req_s2 == msiec_pkg::REQ_RESTART) begin
			pc_nxt   = start_pc_q;
			halt_nxt = 1'b0;
			w        = 1'b1;
			tgt      = msiec_pkg::REG_SP;
			v        = init_sp_q;
		end else if (req_s2 == msiec_pkg::REQ_EXEC && !halt_q) begin
			if (op == msiec_pkg::OP_RTYPE) begin
				tgt = iw_s2[15:11];
				w   = 1'b1;
				unique case (fn)
					msiec_pkg::FN_ADD:  v = a_s2 + b_s2;
					msiec_pkg::FN_SUB:  v = a_s2 - b_s2;
					msiec_pkg::FN_AND:  v = a_s2 & b_s2;
					msiec_pkg::FN_OR:   v = a_s2 | b_s2;
					msiec_pkg::FN_XOR:  v = a_s2 ^ b_s2;
					msiec_pkg::FN_NOR:  v = ~(a_s2 | b_s2);
					msiec_pkg::FN_NAND: v = ~(a_s2 & b_s2);
					msiec_pkg::FN_SLT:  v = {31'd0, $signed(a_s2) < $signed(b_s2)};
					msiec_pkg::FN_SLL:  v = b_s2 << sh;
					msiec_pkg::FN_SRL:  v = b_s2 >> sh;
					msiec_pkg::FN_SRA:  v = $unsigned($signed(b_s2) >>> sh);
					msiec_pkg::FN_JR: begin
						w   = 1'b0;
						nxt = a_s2;
					end
					default: w = 1'b0;
				endcase
				pc_nxt = nxt;
			end else if (op == msiec_pkg::OP_J || op == msiec_pkg::OP_JAL) begin
				if (op == msiec_pkg::OP_JAL) begin
					w   = 1'b1;
					tgt = msiec_pkg::REG_RA;
					v   = nxt;
				end
				pc_nxt = {nxt[31:28], iw_s2[25:0], 2'b00};
			end else if (op == msiec_pkg::OP_HALT) begin
				halt_nxt = 1'b1;
			end else begin
				tgt = iw_s2[20:16];
				unique case (op)
					msiec_pkg::OP_ADDI: begin w = 1'b1; v = a_s2 + imm; end
					msiec_pkg::OP_LUI:  begin w = 1'b1; v = {iw_s2[15:0], 16'd0}; end
					msiec_pkg::OP_ANDI: begin w = 1'b1; v = a_s2 & zimm; end
					msiec_pkg::OP_ORI:  begin w = 1'b1; v = a_s2 | zimm; end
					msiec_pkg::OP_NORI: begin w = 1'b1; v = ~(a_s2 | zimm); end
					msiec_pkg::OP_SLTI: begin
						w = 1'b1;
						v = {31'd0, $signed(a_s2) < $signed(imm)};
					end
					msiec_pkg::OP_BEQ: if (a_s2 == b_s2) nxt = nxt + {imm[29:0], 2'b00};
					msiec_pkg::OP_BNE: if (a_s2 != b_s2) nxt = nxt + {imm[29:0], 2'b00};
					msiec_pkg::OP_LW:  begin w = 1'b1; ld = 1'b1; v = word; end
					msiec_pkg::OP_LH:  begin w = 1'b1; ld = 1'b1; v = {{16{hsel[15]}}, hsel}; end
					msiec_pkg::OP_LHU: begin w = 1'b1; ld = 1'b1; v = {16'd0, hsel}; end
					msiec_pkg::OP_LB:  begin w = 1'b1; ld = 1'b1; v = {{24{bsel[7]}}, bsel}; end
					msiec_pkg::OP_LBU: begin w = 1'b1; ld = 1'b1; v = {24'd0, bsel}; end
					msiec_pkg::OP_SW: begin
						mw = 1'b1;
						dm_wdata = b_s2;
					end
					msiec_pkg::OP_SH: begin
						mw = 1'b1;
						dm_wdata = (off == 2'd0) ? {b_s2[15:0], word[15:0]}
						                         : {word[31:16], b_s2[15:0]};
					end
					msiec_pkg::OP_SB: begin
						mw = 1'b1;
						case (off)
							2'd0:    dm_wdata = {b_s2[7:0], word[23:0]};
							2'd1:    dm_wdata = {word[31:24], b_s2[7:0], word[15:0]};
							2'd2:    dm_wdata = {word[31:16], b_s2[7:0], word[7:0]};
							default: dm_wdata = {word[31:8], b_s2[7:0]};
						endcase
					end
					default: known = 1'b0;
				endcase
				dm_we = mw;
				if (known) pc_nxt = nxt;
			end
		end

		if (w && tgt != 5'd0) begin
			rf_we    = 1'b1;
			rf_waddr = tgt;
			rf_wdata = v;
		end

		res.pc_after    = pc_nxt;
		res.reg_written = rf_we;
		res.dest_reg    = rf_waddr;
		res.dest_value  = rf_wdata;
		res.mem_written = mw;
		res.mem_address = (mw || ld) ? ea_s2 : '0;
		res.mem_value   = mw ? dm_wdata : (ld ? word : '0);
		res.halted      = halt_nxt;
	end

	assign m_tdata = out_q;

	`MSIEC_ASSERT_IMP(a_no_r0_write, m_tvalid && out_q.reg_written, out_q.dest_reg != 5'd0, "register zero reported as written")
	`MSIEC_ASSERT_IMP(a_one_write, m_tvalid && out_q.mem_written, !out_q.reg_written, "store also wrote a register")
	`MSIEC_ASSERT_IMP(a_halt_quiet, m_tvalid && out_q.halted, !out_q.reg_written && !out_q.mem_written, "halted core changed state")
	`MSIEC_ASSERT_NXT(a_rf_zero_invalid, 1'b1, !rf_valid_q[0], "register zero marked written")
endmodule
`default_nettype wire

// File: tb/tb_mips_subset_instruction_execute_core.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_mips_subset_instruction_execute_core;
	import msiec_pkg::*;

	localparam logic [5:0] OP_UNDEF = 6'h3E;
	localparam logic [5:0] FN_UNDEF = 6'h3F;
	localparam logic [1:0] REQ_IGNORED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 300;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	mips_subset_instruction_execute_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// architectural copy
	logic [31:0] gpr [32];
	logic [31:0] dmem [256];
	bit          dmem_valid [256];
	logic [31:0] arch_pc;
	logic        arch_halt;
	logic [31:0] cfg_start_pc;
	logic [31:0] cfg_init_sp;

	result_t     pending_results [$];
	int          errors;
	bit          gaps_on;
	bit          stalls_on;
	bit          hold_now;
	int          idle_cycles;

	typedef struct {
		logic [1:0]  req;
		logic [31:0] iw;
		logic [7:0]  pidx;
		logic [31:0] pword;
		bit          typed;
		result_t     want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] sa);
		return {OP_RTYPE, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic bit is_load(logic [5:0] op);
		return op == OP_LW || op == OP_LH || op == OP_LHU || op == OP_LB || op == OP_LBU;
	endfunction

	function automatic result_t retire(logic [1:0] req, logic [31:0] iw, logic [7:0] pidx,
			logic [31:0] pword);
		result_t     r;
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sa, tgt, bsh;
		logic [31:0] a, b, imm, zimm, nxt, ea, wd, v;
		logic [7:0]  widx;
		logic [1:0]  off;
		logic        w, known, mw;
		r = '0;
		mw = 1'b0;
		if (req == REQ_PRELOAD) begin
			dmem[pidx] = pword;
			dmem_valid[pidx] = 1'b1;
		end else if (req == REQ_RESTART) begin
			arch_pc = cfg_start_pc;
			gpr[REG_SP] = cfg_init_sp;
			arch_halt = 1'b0;
			r.reg_written = 1'b1;
			r.dest_reg = REG_SP;
			r.dest_value = cfg_init_sp;
		end else if (req == REQ_EXEC && !arch_halt) begin
			op = iw[31:26]; rs = iw[25:21]; rt = iw[20:16]; rd = iw[15:11];
			sa = iw[10:6]; fn = iw[5:0];
			a = gpr[rs]; b = gpr[rt];
			imm = sx16(iw[15:0]); zimm = {16'h0, iw[15:0]};
			nxt = arch_pc + 32'd4;
			ea = a + imm; widx = ea[9:2]; off = ea[1:0];
			wd = dmem[widx];
			bsh = {~off, 3'b000};
			w = 1'b0; v = '0; tgt = '0;
			if (op == OP_RTYPE) begin
				tgt = rd; w = 1'b1;
				case (fn)
					FN_ADD: v = a + b;
					FN_SUB: v = a - b;
					FN_AND: v = a & b;
					FN_OR: v = a | b;
					FN_XOR: v = a ^ b;
					FN_NOR: v = ~(a | b);
					FN_NAND: v = ~(a & b);
					FN_SLT: v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
					FN_SLL: v = b << sa;
					FN_SRL: v = b >> sa;
					FN_SRA: v = $signed(b) >>> sa;
					FN_JR: begin
						w = 1'b0; nxt = a;
					end
					default: w = 1'b0;
				endcase
				arch_pc = nxt;
			end else if (op == OP_J || op == OP_JAL) begin
				if (op == OP_JAL) begin
					w = 1'b1; tgt = REG_RA; v = nxt;
				end
				arch_pc = {nxt[31:28], iw[25:0], 2'b00};
			end else if (op == OP_HALT) begin
				arch_halt = 1'b1;
			end else begin
				known = 1'b1;
				tgt = rt;
				case (op)
					OP_ADDI: begin w = 1'b1; v = a + imm; end
					OP_LUI: begin w = 1'b1; v = {iw[15:0], 16'h0}; end
					OP_ANDI: begin w = 1'b1; v = a & zimm; end
					OP_ORI: begin w = 1'b1; v = a | zimm; end
					OP_NORI: begin w = 1'b1; v = ~(a | zimm); end
					OP_SLTI: begin
						w = 1'b1; v = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
					end
					OP_BEQ: if (a == b) nxt = nxt + (imm << 2);
					OP_BNE: if (a != b) nxt = nxt + (imm << 2);
					OP_LW: begin
						w = 1'b1; v = wd; r.mem_address = ea; r.mem_value = wd;
					end
					OP_LH, OP_LHU: begin
						w = 1'b1; r.mem_address = ea; r.mem_value = wd;
						v = (off == 2'd0) ? {16'h0, wd[31:16]} : {16'h0, wd[15:0]};
						if (op == OP_LH) v = sx16(v[15:0]);
					end
					OP_LB, OP_LBU: begin
						w = 1'b1; r.mem_address = ea; r.mem_value = wd;
						v = (wd >> bsh) & 32'hFF;
						if (op == OP_LB) v = {{24{v[7]}}, v[7:0]};
					end
					OP_SW: begin wd = b; mw = 1'b1; end
					OP_SH: begin
						if (off == 2'd0) wd = {b[15:0], wd[15:0]};
						else wd = {wd[31:16], b[15:0]};
						mw = 1'b1;
					end
					OP_SB: begin
						wd = (wd & ~(32'hFF << bsh)) | ({24'h0, b[7:0]} << bsh);
						mw = 1'b1;
					end
					default: known = 1'b0;
				endcase
				if (mw) begin
					dmem[widx] = wd;
					dmem_valid[widx] = 1'b1;
					r.mem_written = 1'b1;
					r.mem_address = ea;
					r.mem_value = wd;
				end
				if (known) arch_pc = nxt;
			end
			if (w && tgt != 5'd0) begin
				gpr[tgt] = v;
				r.reg_written = 1'b1;
				r.dest_reg = tgt;
				r.dest_value = v;
			end
		end
		r.pc_after = arch_pc;
		r.halted = arch_halt;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic cfg_write(logic idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == CFG_START_PC) cfg_start_pc = val;
		else cfg_init_sp = val;
		@(posedge clk);
	endtask

	task automatic send_word(logic [1:0] req, logic [31:0] iw, logic [7:0] pidx,
			logic [31:0] pword, bit typed, result_t want);
		result_t r;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		r = retire(req, iw, pidx, pword);
		pending_results.push_back(typed ? want : r);
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {pword, pidx, iw};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random();
		logic [1:0]  req;
		logic [31:0] iw, pword, ea;
		logic [7:0]  pidx;
		int          k;
		req = REQ_EXEC;
		iw = $urandom; pidx = 8'($urandom); pword = $urandom;
		k = $urandom_range(0, 99);
		if (k < 3) req = REQ_RESTART;
		else if (k < 5) req = REQ_IGNORED;
		else if (k < 12) req = REQ_PRELOAD;
		else if (k < 13) iw[31:26] = OP_HALT;
		else if (k < 16) iw = $urandom;
		else if (k < 42) begin
			iw[31:26] = OP_RTYPE;
			case ($urandom_range(0, 12))
				0: iw[5:0] = FN_ADD;
				1: iw[5:0] = FN_SUB;
				2: iw[5:0] = FN_AND;
				3: iw[5:0] = FN_OR;
				4: iw[5:0] = FN_XOR;
				5: iw[5:0] = FN_NOR;
				6: iw[5:0] = FN_NAND;
				7: iw[5:0] = FN_SLT;
				8: iw[5:0] = FN_SLL;
				9: iw[5:0] = FN_SRL;
				10: iw[5:0] = FN_SRA;
				11: iw[5:0] = FN_JR;
				default: ;
			endcase
		end else if (k < 62) begin
			case ($urandom_range(0, 7))
				0: iw[31:26] = OP_LW;
				1: iw[31:26] = OP_LH;
				2: iw[31:26] = OP_LHU;
				3: iw[31:26] = OP_LB;
				4: iw[31:26] = OP_LBU;
				5: iw[31:26] = OP_SW;
				6: iw[31:26] = OP_SH;
				default: iw[31:26] = OP_SB;
			endcase
		end else begin
			case ($urandom_range(0, 9))
				0: iw[31:26] = OP_ADDI;
				1: iw[31:26] = OP_SLTI;
				2: iw[31:26] = OP_ANDI;
				3: iw[31:26] = OP_ORI;
				4: iw[31:26] = OP_NORI;
				5: iw[31:26] = OP_LUI;
				6: iw[31:26] = OP_BEQ;
				7: iw[31:26] = OP_BNE;
				8: iw[31:26] = OP_J;
				default: iw[31:26] = OP_JAL;
			endcase
		end
		if (req == REQ_EXEC && !arch_halt && is_load(iw[31:26])) begin
			ea = gpr[iw[25:21]] + sx16(iw[15:0]);
			if (!dmem_valid[ea[9:2]]) begin
				req = REQ_PRELOAD;
				pidx = ea[9:2];
			end
		end
		send_word(req, iw, pidx, pword, 1'b0, '0);
	endtask

	function automatic result_t rres(logic [31:0] pc, logic wr, logic [4:0] rd,
			logic [31:0] val);
		result_t r;
		r = '0;
		r.pc_after = pc; r.reg_written = wr; r.dest_reg = rd; r.dest_value = val;
		return r;
	endfunction

	task automatic add_row(logic [1:0] req, logic [31:0] iw, logic [7:0] pidx,
			logic [31:0] pword, bit typed, result_t want);
		dir_row_t d;
		d.req = req; d.iw = iw; d.pidx = pidx; d.pword = pword;
		d.typed = typed; d.want = want;
		dir_rows.push_back(d);
	endtask

	task automatic add_exec(logic [31:0] iw);
		add_row(REQ_EXEC, iw, 8'h0, 32'h0, 1'b0, '0);
	endtask

	// receiver side
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_now) begin
				hold_now = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stalls_on && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_tdata);
				errors++;
			end else begin
				exp = pending_results.pop_front();
				if (got.pc_after !== exp.pc_after) begin
					$display("%0t: pc_after exp %h got %h", $time, exp.pc_after, got.pc_after);
					errors++;
				end
				if (got.reg_written !== exp.reg_written) begin
					$display("%0t: reg_written exp %b got %b", $time, exp.reg_written,
						got.reg_written);
					errors++;
				end
				if (got.dest_reg !== exp.dest_reg) begin
					$display("%0t: dest_reg exp %0d got %0d", $time, exp.dest_reg, got.dest_reg);
					errors++;
				end
				if (got.dest_value !== exp.dest_value) begin
					$display("%0t: dest_value exp %h got %h", $time, exp.dest_value,
						got.dest_value);
					errors++;
				end
				if (got.mem_written !== exp.mem_written) begin
					$display("%0t: mem_written exp %b got %b", $time, exp.mem_written,
						got.mem_written);
					errors++;
				end
				if (got.mem_address !== exp.mem_address) begin
					$display("%0t: mem_address exp %h got %h", $time, exp.mem_address,
						got.mem_address);
					errors++;
				end
				if (got.mem_value !== exp.mem_value) begin
					$display("%0t: mem_value exp %h got %h", $time, exp.mem_value,
						got.mem_value);
					errors++;
				end
				if (got.halted !== exp.halted) begin
					$display("%0t: halted exp %b got %b", $time, exp.halted, got.halted);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_mips_subset_instruction_execute_core NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int n;
		errors = 0; idle_cycles = 0;
		gaps_on = 1'b1; stalls_on = 1'b1; hold_now = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0; s_tdata <= '0; s_tuser <= '0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		for (int i = 0; i < 32; i++) gpr[i] = '0;
		for (int i = 0; i < 256; i++) begin
			dmem[i] = '0; dmem_valid[i] = 1'b0;
		end
		arch_pc = '0; arch_halt = 1'b0; cfg_start_pc = '0; cfg_init_sp = '0;

		add_row(REQ_EXEC, enc_i(OP_ADDI, 5'd0, 5'd1, 16'hFFFF), 8'h0, 32'h0, 1'b1,
			rres(32'h4, 1'b1, 5'd1, 32'hFFFFFFFF));
		add_row(REQ_EXEC, enc_i(OP_LUI, 5'd0, 5'd2, 16'h8000), 8'h0, 32'h0, 1'b1,
			rres(32'h8, 1'b1, 5'd2, 32'h80000000));
		add_row(REQ_EXEC, enc_r(FN_ADD, 5'd1, 5'd1, 5'd0, 5'd0), 8'h0, 32'h0, 1'b1,
			rres(32'hC, 1'b0, 5'd0, 32'h0));
		add_row(REQ_PRELOAD, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 1'b1,
			rres(32'hC, 1'b0, 5'd0, 32'h0));
		add_row(REQ_PRELOAD, 32'h0, 8'h00, 32'h80FF7F01, 1'b0, '0);
		add_exec(enc_r(FN_SUB, 5'd2, 5'd1, 5'd3, 5'd0));
		add_exec(enc_r(FN_SLT, 5'd2, 5'd1, 5'd4, 5'd0));
		add_exec(enc_r(FN_SRA, 5'd0, 5'd2, 5'd5, 5'd31));
		add_exec(enc_r(FN_NAND, 5'd1, 5'd2, 5'd6, 5'd0));
		add_exec(enc_i(OP_LW, 5'd0, 5'd7, 16'hFFFC));
		add_exec(enc_i(OP_LH, 5'd0, 5'd8, 16'h0000));
		add_exec(enc_i(OP_LHU, 5'd0, 5'd9, 16'h0001));
		add_exec(enc_i(OP_LB, 5'd0, 5'd10, 16'h0000));
		add_exec(enc_i(OP_LBU, 5'd0, 5'd11, 16'h0003));
		add_exec(enc_i(OP_SB, 5'd0, 5'd1, 16'h0002));
		add_exec(enc_i(OP_SH, 5'd0, 5'd2, 16'h0003));
		add_exec(enc_i(OP_SW, 5'd0, 5'd2, 16'h03FC));
		add_exec(enc_i(OP_SLTI, 5'd2, 5'd12, 16'hFFFF));
		add_exec(enc_i(OP_NORI, 5'd0, 5'd13, 16'hFFFF));
		add_exec(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
		add_exec(enc_i(OP_BNE, 5'd1, 5'd0, 16'h7FFF));
		add_exec({OP_JAL, 26'h3FFFFFF});
		add_exec(enc_r(FN_JR, 5'd1, 5'd0, 5'd0, 5'd0));
		add_exec(enc_r(FN_UNDEF, 5'd1, 5'd2, 5'd14, 5'd0));
		add_exec(enc_i(OP_UNDEF, 5'd1, 5'd15, 16'h1234));
		add_exec(enc_i(OP_HALT, 5'd0, 5'd0, 16'h0));
		add_exec(enc_i(OP_ADDI, 5'd0, 5'd16, 16'h0001));
		add_row(REQ_IGNORED, 32'h0, 8'h0, 32'h0, 1'b0, '0);
		add_row(REQ_RESTART, 32'h0, 8'h0, 32'h0, 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].req, dir_rows[i].iw, dir_rows[i].pidx, dir_rows[i].pword,
				dir_rows[i].typed, dir_rows[i].want);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					cfg_write(CFG_START_PC, 32'h0);
					cfg_write(CFG_INIT_SP, 32'h0);
				end
				1: begin
					cfg_write(CFG_START_PC, 32'hFFFFFFFF);
					cfg_write(CFG_INIT_SP, 32'hFFFFFFFF);
				end
				2: begin
					cfg_write(CFG_START_PC, $urandom);
					cfg_write(CFG_INIT_SP, $urandom);
				end
				default: begin
					cfg_write(CFG_START_PC, {22'd0, 8'($urandom_range(0, 255)), 2'b00});
					cfg_write(CFG_INIT_SP, 32'h000003FC);
					gaps_on = 1'b0;
					stalls_on = 1'b0;
				end
			endcase
			n = 300;
			if (ph == 0) begin
				for (int i = 0; i < 256; i++)
					send_word(REQ_PRELOAD, $urandom, i[7:0], $urandom, 1'b0, '0);
				n = 260;
			end
			if (ph == 1) begin
				gaps_on = 1'b0;
				hold_now = 1'b1;
				for (int i = 0; i < 40; i++) send_random();
				gaps_on = 1'b1;
				n = 260;
			end
			for (int i = 0; i < n; i++) send_random();
			drain();
		end

		if (errors == 0) begin
			$display("tb_mips_subset_instruction_execute_core OK");
		end else begin
			$display("tb_mips_subset_instruction_execute_core NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire
